>>> rtl/core/assert_macros.svh
// Assertion macros shared by the dash pattern query RTL.
// Each macro expects the signals aclk and aresetn to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that is checked at every clock edge outside reset.
`define DPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// An implication that is checked at every clock edge outside reset.
`define DPQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/dpq_pkg.sv
// Package for the dash pattern position query block: widths, register indexes,
// controller states and the command and status words. Depends on nothing.
`default_nettype none

package dpq_pkg;

    localparam int SEG_REGS         = 6;
    localparam int MAX_SEGMENTS_DEF = 6;
    localparam int SEG_W            = 21;
    localparam int POS_W            = 32;
    localparam int LEN_W            = 23;
    localparam int DELTA_W          = 24;
    localparam int COUNT_W          = 3;
    localparam int CFG_IDX_W        = 3;
    localparam int SEG_IDX_W        = 3;
    localparam int DIV_STEPS        = POS_W;
    localparam int STEP_W           = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] REG_SEG_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_LEN_0 = 3'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_CHECK,
        ST_DIV,
        ST_WRAP,
        ST_WALK,
        ST_DONE
    } dpq_state_t;

    typedef struct packed {
        logic                 load;
        logic                 sum_step;
        logic                 div_init;
        logic                 div_step;
        logic                 wrap;
        logic                 walk_step;
        logic                 out_load;
        logic [SEG_IDX_W-1:0] idx;
    } dpq_cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0] n_eff;
        logic               invalid;
        logic               out_busy;
    } dpq_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/dpq_ctrl.sv
// Controller of the dash pattern query: sequences summing, division, wrapping
// and the segment walk. Depends on dpq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dpq_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output dpq_pkg::dpq_cmd_t      cmd,
    input  wire dpq_pkg::dpq_sts_t sts
);
    import dpq_pkg::*;

    dpq_state_t        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (cnt_reg == STEP_W'(sts.n_eff)) begin
                    state_next = ST_CHECK;
                end else begin
                    cmd.sum_step = 1'b1;
                    cmd.idx      = cnt_reg[SEG_IDX_W-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
            end
            ST_CHECK: begin
                if (sts.invalid) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == STEP_W'(DIV_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_WRAP;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_WRAP: begin
                cmd.wrap   = 1'b1;
                cnt_next   = '0;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                cmd.walk_step = 1'b1;
                cmd.idx       = cnt_reg[SEG_IDX_W-1:0];
                if (cnt_reg[SEG_IDX_W-1:0] == sts.n_eff - 1'b1) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `DPQ_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !sts.out_busy,
        "Result word loaded while the previous one is still held.")
    `DPQ_ASSERT(a_one_action, $onehot0({cmd.load, cmd.sum_step, cmd.div_step,
        cmd.walk_step, cmd.out_load}), "More than one datapath action at once.")
    `DPQ_ASSERT_IMPL(a_walk_needs_segments, state_reg == ST_WALK, sts.n_eff != '0,
        "Segment walk entered with no segments in use.")

endmodule

`default_nettype wire

>>> rtl/core/dpq_datapath.sv
// Datapath of the dash pattern query: configuration registers, pattern length,
// restoring remainder unit, wrap, segment walk and result register.
// Depends on dpq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dpq_datapath #(
    parameter int MAX_SEGMENTS = dpq_pkg::MAX_SEGMENTS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    input  wire logic [dpq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic signed [dpq_pkg::SEG_W-1:0]     cfg_data,
    input  wire logic signed [dpq_pkg::POS_W-1:0]     s_position,
    input  wire dpq_pkg::dpq_cmd_t                    cmd,
    output dpq_pkg::dpq_sts_t                         sts,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [dpq_pkg::DELTA_W-1:0]        m_delta,
    output logic                                      m_dash_present,
    output logic                                      m_dash_not_found,
    output logic                                      m_invalid_pattern
);
    import dpq_pkg::*;

    localparam int NSEG  = (MAX_SEGMENTS < SEG_REGS) ? MAX_SEGMENTS : SEG_REGS;
    localparam int IDX_W = (NSEG > 1) ? $clog2(NSEG) : 1;

    logic [COUNT_W-1:0]      count_reg;
    logic signed [SEG_W-1:0] seg_reg [NSEG];

    logic               neg_reg;
    logic [POS_W-1:0]   pmag_reg;
    logic [POS_W-1:0]   dvd_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   rem_reg;
    logic [LEN_W-1:0]   r_reg;
    logic [LEN_W-1:0]   total_reg;
    logic               found_delta_reg;
    logic               found_dash_reg;
    logic               dash_reg;
    logic signed [DELTA_W-1:0] delta_reg;

    logic                      m_valid_reg;
    logic signed [DELTA_W-1:0] m_delta_reg;
    logic                      m_dash_reg;
    logic                      m_nf_reg;
    logic                      m_inv_reg;

    logic signed [SEG_W-1:0] seg_sel;
    logic [SEG_W-1:0]        seg_mag;
    logic [LEN_W-1:0]        total_next;
    logic [LEN_W-1:0]        diff;
    logic [LEN_W:0]          trial;
    logic                    trial_ge;
    logic [LEN_W-1:0]        rem_next;
    logic [LEN_W-1:0]        r_next;
    logic [POS_W-1:0]        pos_mag;
    logic                    cfg_seg_hit;
    logic [CFG_IDX_W-1:0]    cfg_seg_idx;

    assign seg_sel    = seg_reg[cmd.idx[IDX_W-1:0]];
    assign seg_mag    = seg_sel[SEG_W-1] ? SEG_W'(-seg_sel) : seg_sel;
    assign total_next = total_reg + LEN_W'(seg_mag);
    assign diff       = total_next - r_reg;

    assign trial    = {rem_reg, dvd_reg[POS_W-1]};
    assign trial_ge = trial >= {1'b0, len_reg};
    assign rem_next = trial_ge ? LEN_W'(trial - {1'b0, len_reg}) : trial[LEN_W-1:0];

    assign pos_mag = s_position[POS_W-1] ? POS_W'(-s_position) : s_position;

    always_comb begin
        if (neg_reg) begin
            r_next = (rem_reg == '0) ? '0 : len_reg - rem_reg;
        end else if (pmag_reg > POS_W'(len_reg)) begin
            r_next = rem_reg;
        end else begin
            r_next = pmag_reg[LEN_W-1:0];
        end
    end

    assign cfg_seg_idx = cfg_index - REG_SEG_LEN_0;
    assign cfg_seg_hit = (cfg_index >= REG_SEG_LEN_0)
                         && ({1'b0, cfg_seg_idx} < (CFG_IDX_W + 1)'(NSEG));

    always_comb begin
        sts.n_eff    = (count_reg > COUNT_W'(NSEG)) ? COUNT_W'(NSEG) : count_reg;
        sts.invalid  = (sts.n_eff == '0) || (len_reg == '0);
        sts.out_busy = m_valid_reg && !m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int i = 0; i < NSEG; i++) begin
                seg_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            if (cfg_index == REG_SEG_COUNT) begin
                count_reg <= cfg_data[COUNT_W-1:0];
            end else if (cfg_seg_hit) begin
                seg_reg[cfg_seg_idx[IDX_W-1:0]] <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            neg_reg  <= s_position[POS_W-1];
            pmag_reg <= pos_mag;
            len_reg  <= '0;
        end else if (cmd.sum_step) begin
            len_reg <= len_reg + LEN_W'(seg_mag);
        end
        if (cmd.div_init) begin
            dvd_reg <= pmag_reg;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[POS_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (cmd.wrap) begin
            r_reg <= r_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_delta_reg <= 1'b0;
            found_dash_reg  <= 1'b0;
        end else if (cmd.wrap) begin
            found_delta_reg <= 1'b0;
            found_dash_reg  <= 1'b0;
        end else if (cmd.walk_step) begin
            if (total_next >= r_reg) begin
                found_delta_reg <= 1'b1;
            end
            if (total_next > r_reg) begin
                found_dash_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wrap) begin
            total_reg <= '0;
            dash_reg  <= 1'b0;
            delta_reg <= '0;
        end else if (cmd.walk_step) begin
            total_reg <= total_next;
            if (!found_delta_reg && total_next >= r_reg) begin
                delta_reg <= seg_sel[SEG_W-1] ? -$signed({1'b0, diff})
                                               : $signed({1'b0, diff});
            end
            if (!found_dash_reg && total_next > r_reg) begin
                dash_reg <= (seg_sel > 0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (sts.invalid) begin
                m_delta_reg <= '0;
                m_dash_reg  <= 1'b0;
                m_nf_reg    <= 1'b1;
                m_inv_reg   <= 1'b1;
            end else begin
                m_delta_reg <= delta_reg;
                m_dash_reg  <= found_dash_reg && dash_reg;
                m_nf_reg    <= !found_dash_reg;
                m_inv_reg   <= 1'b0;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_delta           = m_delta_reg;
    assign m_dash_present    = m_dash_reg;
    assign m_dash_not_found  = m_nf_reg;
    assign m_invalid_pattern = m_inv_reg;

    `DPQ_ASSERT_IMPL(a_rem_below_len, cmd.wrap, rem_reg < len_reg,
        "Remainder not below the pattern length after division.")
    `DPQ_ASSERT_IMPL(a_wrapped_in_range, cmd.walk_step, r_reg <= len_reg,
        "Wrapped position lies beyond the pattern length.")
    `DPQ_ASSERT_IMPL(a_dash_after_delta, found_dash_reg, found_delta_reg,
        "Dash search ended before the segment end search.")

endmodule

`default_nettype wire

>>> rtl/core/dash_pattern_position_query_top.sv
// Top level of the dash pattern position query: joins controller and datapath.
// Depends on dpq_pkg, dpq_ctrl and dpq_datapath.
//
//   Channel  Direction  Handshake           Payload
//   s_       in         s_valid / s_ready   s_position
//   m_       out        m_valid / m_ready   m_delta, m_dash_present, m_dash_not_found,
//                                           m_invalid_pattern
//   cfg_     in         cfg_valid / ready   cfg_index, cfg_data
//
// A word is summed, checked, divided by the serial remainder unit, wrapped and walked;
// an invalid pattern skips to the result after the check. The divider runs 32 steps.
// Reset is synchronous and active low and clears all configuration registers to zero.
// A finished word waits in the output register while the next word is accepted;
// the block holds only at the end of that word if the output is still stalled.
`default_nettype none

module dash_pattern_position_query_top #(
    parameter int MAX_SEGMENTS = dpq_pkg::MAX_SEGMENTS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [dpq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic signed [dpq_pkg::SEG_W-1:0] cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [dpq_pkg::POS_W-1:0] s_position,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [dpq_pkg::DELTA_W-1:0]    m_delta,
    output logic                                  m_dash_present,
    output logic                                  m_dash_not_found,
    output logic                                  m_invalid_pattern
);
    import dpq_pkg::*;

    dpq_cmd_t cmd;
    dpq_sts_t sts;

    assign cfg_ready = 1'b1;

    dpq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    dpq_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_position        (s_position),
        .cmd               (cmd),
        .sts               (sts),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_delta           (m_delta),
        .m_dash_present    (m_dash_present),
        .m_dash_not_found  (m_dash_not_found),
        .m_invalid_pattern (m_invalid_pattern)
    );

endmodule

`default_nettype wire
